@@ src/gbba_pkg.sv @@
// Shared types and constants of the grouped bitmap block allocator.
// Depends on nothing; every other file refers to it by scoped names.
package gbba_pkg;

	localparam int BLK_W     = 14;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 11;
	localparam int BPG_REG_W = 11;
	localparam int GRP_REG_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int WORD_W    = 64;
	localparam int BIT_W     = 6;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_GROUP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE    = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE_FREE    = 2'd2;
	localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd3;

	typedef struct packed {
		logic             command;
		logic [BLK_W-1:0] block_number;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BLK_W-1:0]  allocated_block;
		logic [BLK_W-1:0]  total_used;
	} out_item_t;

endpackage

@@ src/gbba_bitmap_mem.sv @@
// Usage bitmap memory: one write port, one registered read port, and a
// zeroing sweep after reset. Uses gbba_pkg for the word width.
module gbba_bitmap_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [gbba_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [gbba_pkg::WORD_W-1:0] rdata,
	output logic                        clearing
);

	logic [gbba_pkg::WORD_W-1:0] mem [DEPTH];
	logic [AW-1:0]               clr_addr_q;
	logic                        clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign clearing = clearing_q;

endmodule

@@ src/gbba_locate.sv @@
// Block-to-group mapping by repeated subtraction, one group per cycle.
// Flags a block beyond the active groups. Uses gbba_pkg for field widths.
module gbba_locate #(
	parameter int BPGW = 11,
	parameter int NGW  = 4,
	parameter int GW   = 3,
	parameter int IW   = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gbba_pkg::BLK_W-1:0] dividend,
	input  logic [BPGW-1:0]            divisor,
	input  logic [NGW-1:0]             groups,
	output logic                       done,
	output logic                       invalid,
	output logic [GW-1:0]              group,
	output logic [IW-1:0]              index
);

	logic [gbba_pkg::BLK_W-1:0] rem_q;
	logic [GW-1:0]              quo_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       invalid_q;
	logic [gbba_pkg::BLK_W-1:0] div_ext;

	assign div_ext = gbba_pkg::BLK_W'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			invalid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_q < div_ext) begin
					busy_q    <= 1'b0;
					done_q    <= 1'b1;
					invalid_q <= 1'b0;
				end else if (NGW'(quo_q) == groups - NGW'(1)) begin
					// past the last active group
					busy_q    <= 1'b0;
					done_q    <= 1'b1;
					invalid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy_q && rem_q >= div_ext && NGW'(quo_q) != groups - NGW'(1)) begin
			rem_q <= rem_q - div_ext;
			quo_q <= quo_q + GW'(1);
		end
	end

	assign done    = done_q;
	assign invalid = invalid_q;
	assign group   = quo_q;
	assign index   = IW'(rem_q);

endmodule

@@ src/grouped_bitmap_block_allocator.sv @@
// Top level of the grouped bitmap block allocator: command sequencer, group
// counts, configuration and output register. Uses gbba_pkg, gbba_locate and
// gbba_bitmap_mem.
//
//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+-----------------------------
//  in      | in_valid, in_stall, in_data      | into      | one command per transaction
//  out     | out_valid, out_stall, out_data   | out of    | one result per transaction
//  cfg     | cfg_we, cfg_index, cfg_data      | into      | register write, no wait
//
// One command at a time. Allocate: the groups in use are checked in turn (full
// groups are skipped), and the words of a group with room are read from the
// bitmap memory and scanned for the lowest clear bit, which is then set.
// Free: the group-mapping subtractor finds the group and index (or flags the block invalid).
// After reset the bitmap memory is zeroed in one pass of one word a cycle over all
// MAX_GROUPS * ceil(MAX_BLOCKS_PER_GROUP/64) words, and in_stall stays high.
// The next command is taken while a result waits on out_stall; the block then
// holds its own result until the output register frees.
module grouped_bitmap_block_allocator #(
	parameter int MAX_GROUPS           = 8,
	parameter int MAX_BLOCKS_PER_GROUP = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  gbba_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output gbba_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [gbba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gbba_pkg::CFG_W-1:0]     cfg_data
);

	localparam int WPG   = (MAX_BLOCKS_PER_GROUP + 63) / 64;
	localparam int TOTAL = MAX_GROUPS * WPG;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BPGW  = $clog2(MAX_BLOCKS_PER_GROUP + 1);
	localparam int NGW   = $clog2(MAX_GROUPS + 1);
	localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int IW    = $clog2(MAX_BLOCKS_PER_GROUP);
	localparam int WGW   = (WPG > 1) ? $clog2(WPG) : 1;
	localparam int NWW   = WGW + 1;
	localparam int CW    = BPGW;
	localparam int TW    = $clog2(MAX_GROUPS * MAX_BLOCKS_PER_GROUP + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOCATE = 3'd1;
	localparam logic [2:0] S_GCHECK = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FCHECK = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	function automatic logic [gbba_pkg::BIT_W-1:0] first_zero(
		input logic [gbba_pkg::WORD_W-1:0] w
	);
		logic [gbba_pkg::BIT_W-1:0] idx;
		idx = '0;
		for (int i = gbba_pkg::WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = gbba_pkg::BIT_W'(i);
			end
		end
		return idx;
	endfunction

	// configuration
	logic [gbba_pkg::BPG_REG_W-1:0] cfg_bpg_q;
	logic [gbba_pkg::GRP_REG_W-1:0] cfg_groups_q;
	logic [BPGW-1:0]                bpg;
	logic [NGW-1:0]                 ngroups;

	// sequencer state
	logic [2:0]                     state_q;
	logic [NGW-1:0]                 cur_g_q;
	logic [TW-1:0]                  base_q;
	logic [AW-1:0]                  gaddr_q;
	logic [WGW-1:0]                 cw_s1;
	logic [AW-1:0]                  faddr_q;
	logic [gbba_pkg::BIT_W-1:0]     fbit_q;
	logic [gbba_pkg::STAT_W-1:0]    res_status_q;
	logic [gbba_pkg::BLK_W-1:0]     res_block_q;
	logic [CW-1:0]                  cnt_q [MAX_GROUPS];
	logic [TW-1:0]                  total_q;
	logic                           out_valid_q;
	gbba_pkg::out_item_t            out_q;

	// memory and locate unit
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [gbba_pkg::WORD_W-1:0]    mem_wdata;
	logic                           mem_re;
	logic [AW-1:0]                  mem_raddr;
	logic [gbba_pkg::WORD_W-1:0]    mem_rdata;
	logic                           clearing;
	logic                           loc_start;
	logic                           loc_done;
	logic                           loc_invalid;
	logic [GW-1:0]                  loc_group;
	logic [IW-1:0]                  loc_index;
	logic [AW-1:0]                  loc_addr;

	// scan datapath
	logic                           in_accept;
	logic                           out_free;
	logic [GW-1:0]                  cg;
	logic [CW-1:0]                  cnt_cur;
	logic [NWW-1:0]                 nwords;
	logic [NWW-1:0]                 cw_next;
	logic                           last_word;
	logic [31:0]                    lim;
	logic [gbba_pkg::WORD_W-1:0]    valid_mask;
	logic [gbba_pkg::WORD_W-1:0]    masked;
	logic                           found;
	logic [gbba_pkg::BIT_W-1:0]     zbit;
	logic [TW-1:0]                  grant;
	logic [gbba_pkg::WORD_W-1:0]    fbit_mask;

	always_comb begin
		if (cfg_bpg_q == '0) begin
			bpg = BPGW'(1);
		end else if (32'(cfg_bpg_q) > 32'(MAX_BLOCKS_PER_GROUP)) begin
			bpg = BPGW'(MAX_BLOCKS_PER_GROUP);
		end else begin
			bpg = BPGW'(cfg_bpg_q);
		end
		if (cfg_groups_q == '0) begin
			ngroups = NGW'(1);
		end else if (32'(cfg_groups_q) > 32'(MAX_GROUPS)) begin
			ngroups = NGW'(MAX_GROUPS);
		end else begin
			ngroups = NGW'(cfg_groups_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bpg_q    <= gbba_pkg::BPG_REG_W'(1024);
			cfg_groups_q <= gbba_pkg::GRP_REG_W'(8);
		end else if (cfg_we) begin
			if (cfg_index == gbba_pkg::REG_BLOCKS_PER_GROUP) begin
				cfg_bpg_q <= cfg_data;
			end
			if (cfg_index == gbba_pkg::REG_GROUPS_IN_USE) begin
				cfg_groups_q <= cfg_data[gbba_pkg::GRP_REG_W-1:0];
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE) || clearing;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign cg      = cur_g_q[GW-1:0];
	assign cnt_cur = cnt_q[cg];

	// word geometry of the current scan position
	assign nwords    = NWW'((32'(bpg) + 32'd63) >> 6);
	assign cw_next   = NWW'(cw_s1) + NWW'(1);
	assign last_word = (cw_next == nwords);
	assign lim       = 32'(bpg) - (32'(cw_s1) << 6);
	assign valid_mask = (lim >= 32'd64) ? '1 :
		((gbba_pkg::WORD_W'(1) << lim[gbba_pkg::BIT_W-1:0]) - gbba_pkg::WORD_W'(1));
	assign masked    = mem_rdata | ~valid_mask;
	assign found     = (masked != '1);
	assign zbit      = first_zero(masked);
	assign grant     = base_q + TW'({cw_s1, zbit}) + TW'(1);
	assign fbit_mask = gbba_pkg::WORD_W'(1) << fbit_q;

	assign loc_addr  = AW'(32'(loc_group) * 32'(WPG) + 32'(loc_index >> 6));
	assign loc_start = in_accept && (in_data.command == gbba_pkg::CMD_FREE)
		&& (in_data.block_number != '0);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = gaddr_q;
		mem_we    = 1'b0;
		mem_waddr = faddr_q;
		mem_wdata = mem_rdata & ~fbit_mask;
		unique case (state_q)
			S_LOCATE: begin
				mem_re    = loc_done && !loc_invalid;
				mem_raddr = loc_addr;
			end
			S_GCHECK: begin
				mem_re    = (cur_g_q != ngroups) && (32'(cnt_cur) < 32'(bpg));
				mem_raddr = gaddr_q;
			end
			S_SCAN: begin
				// fetch the next word while this one is examined
				mem_re    = !last_word;
				mem_raddr = gaddr_q + AW'(cw_next);
				mem_we    = found;
				mem_waddr = gaddr_q + AW'(cw_s1);
				mem_wdata = mem_rdata | (gbba_pkg::WORD_W'(1) << zbit);
			end
			S_FCHECK: begin
				mem_we = mem_rdata[fbit_q];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (in_data.command == gbba_pkg::CMD_ALLOC) begin
							state_q <= S_GCHECK;
						end else if (in_data.block_number == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_LOCATE;
						end
					end
				end
				S_LOCATE: begin
					if (loc_done) begin
						state_q <= loc_invalid ? S_DONE : S_FCHECK;
					end
				end
				S_GCHECK: begin
					if (cur_g_q == ngroups) begin
						state_q <= S_DONE;
					end else if (32'(cnt_cur) < 32'(bpg)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (found) begin
						cnt_q[cg] <= cnt_cur + CW'(1);
						total_q   <= total_q + TW'(1);
						state_q   <= S_DONE;
					end else if (last_word) begin
						state_q <= S_GCHECK;
					end
				end
				S_FCHECK: begin
					if (mem_rdata[fbit_q]) begin
						cnt_q[cg] <= cnt_cur - CW'(1);
						total_q   <= total_q - TW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_g_q <= '0;
		end else if (in_accept) begin
			cur_g_q <= '0;
		end else if (state_q == S_LOCATE && loc_done) begin
			cur_g_q <= NGW'(loc_group);
		end else if ((state_q == S_GCHECK && cur_g_q != ngroups
				&& 32'(cnt_cur) >= 32'(bpg))
				|| (state_q == S_SCAN && !found && last_word)) begin
			cur_g_q <= cur_g_q + NGW'(1);
		end
	end

	// scan position and result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			base_q       <= '0;
			gaddr_q      <= '0;
			res_status_q <= gbba_pkg::ST_INVALID;
			res_block_q  <= '0;
		end
		unique case (state_q)
			S_LOCATE: begin
				faddr_q <= loc_addr;
				fbit_q  <= gbba_pkg::BIT_W'(loc_index);
			end
			S_GCHECK: begin
				cw_s1 <= '0;
				if (cur_g_q == ngroups) begin
					res_status_q <= gbba_pkg::ST_NONE_FREE;
				end else if (32'(cnt_cur) >= 32'(bpg)) begin
					base_q  <= base_q + TW'(bpg);
					gaddr_q <= gaddr_q + AW'(WPG);
				end
			end
			S_SCAN: begin
				if (found) begin
					res_status_q <= gbba_pkg::ST_OK;
					res_block_q  <= gbba_pkg::BLK_W'(grant);
				end else if (last_word) begin
					base_q  <= base_q + TW'(bpg);
					gaddr_q <= gaddr_q + AW'(WPG);
				end else begin
					cw_s1 <= WGW'(cw_next);
				end
			end
			S_FCHECK: begin
				res_status_q <= mem_rdata[fbit_q] ? gbba_pkg::ST_OK : gbba_pkg::ST_ALREADY_FREE;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.status          <= res_status_q;
			out_q.allocated_block <= res_block_q;
			out_q.total_used      <= gbba_pkg::BLK_W'(total_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	gbba_locate #(
		.BPGW (BPGW),
		.NGW  (NGW),
		.GW   (GW),
		.IW   (IW)
	) u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (loc_start),
		.dividend (in_data.block_number - gbba_pkg::BLK_W'(1)),
		.divisor  (bpg),
		.groups   (ngroups),
		.done     (loc_done),
		.invalid  (loc_invalid),
		.group    (loc_group),
		.index    (loc_index)
	);

	gbba_bitmap_mem #(
		.DEPTH (TOTAL),
		.AW    (AW)
	) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.re       (mem_re),
		.raddr    (mem_raddr),
		.rdata    (mem_rdata),
		.clearing (clearing)
	);

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for grouped_bitmap_block_allocator: a shadow allocator predicts
// every result, directed and random commands are driven across several register settings.
// Depends on gbba_pkg and the RTL top level only.
module tb_top;

	localparam int NUM_GROUPS     = 8;
	localparam int GROUP_BLOCKS   = 1024;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 9;

	logic                dclk_unused_guard;
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	gbba_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	gbba_pkg::out_item_t out_data;
	logic                           cfg_we = 1'b0;
	logic [gbba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gbba_pkg::CFG_W-1:0]     cfg_data = '0;

	// shadow allocator state
	bit                             blk_used [NUM_GROUPS][GROUP_BLOCKS];
	int                             grp_count [NUM_GROUPS];
	int                             used_total = 0;
	logic [gbba_pkg::BPG_REG_W-1:0] bpg_shadow = gbba_pkg::BPG_REG_W'(1024);
	logic [gbba_pkg::GRP_REG_W-1:0] grp_shadow = gbba_pkg::GRP_REG_W'(8);

	gbba_pkg::in_item_t  cmd_backlog[$];
	gbba_pkg::out_item_t awaited_results[$];
	int        cmds_sent = 0;
	int        cmds_taken = 0;
	int        results_seen = 0;
	int        bad_results = 0;
	int        quiet_cycles = 0;
	logic      in_fire = 1'b0;

	int tx_gap = 0, tx_calm = 0;
	int rx_gap = 0, rx_calm = 0, rx_hold = 0, hold_mark = 200;

	int phase_bpg   [0:NUM_PHASES-1] = '{3, 64, 65, 1, 100, 1500, 7, 200, 5};
	int phase_grp   [0:NUM_PHASES-1] = '{2, 3, 2, 8, 1, 9, 15, 5, 4};
	int phase_items [0:NUM_PHASES-1] = '{90, 110, 130, 60, 120, 50, 90, 100, 80};
	int phase_alloc [0:NUM_PHASES-1] = '{60, 80, 70, 55, 75, 80, 60, 60, 50};

	grouped_bitmap_block_allocator #(
		.MAX_GROUPS(NUM_GROUPS),
		.MAX_BLOCKS_PER_GROUP(GROUP_BLOCKS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_bpg();
		int v;
		v = bpg_shadow;
		if (v < 1) v = 1;
		if (v > GROUP_BLOCKS) v = GROUP_BLOCKS;
		return v;
	endfunction

	function automatic int eff_groups();
		int v;
		v = grp_shadow;
		if (v < 1) v = 1;
		if (v > NUM_GROUPS) v = NUM_GROUPS;
		return v;
	endfunction

	function automatic gbba_pkg::out_item_t apply_block_command(gbba_pkg::in_item_t c);
		gbba_pkg::out_item_t r;
		int bpg, ng, g, j, blk;
		bit found;
		r = '0;
		bpg = eff_bpg();
		ng = eff_groups();
		found = 1'b0;
		if (c.command == gbba_pkg::CMD_ALLOC) begin
			r.status = gbba_pkg::ST_NONE_FREE;
			// first fit: skip full groups, take the lowest clear index
			for (g = 0; g < ng && !found; g++) begin
				if (grp_count[g] < bpg) begin
					for (j = 0; j < bpg && !found; j++) begin
						if (!blk_used[g][j]) begin
							blk_used[g][j] = 1'b1;
							grp_count[g]++;
							used_total++;
							r.allocated_block = gbba_pkg::BLK_W'(g * bpg + j + 1);
							r.status = gbba_pkg::ST_OK;
							found = 1'b1;
						end
					end
				end
			end
		end else begin
			blk = c.block_number;
			if (blk == 0 || blk > ng * bpg) begin
				r.status = gbba_pkg::ST_INVALID;
			end else begin
				g = (blk - 1) / bpg;
				j = (blk - 1) % bpg;
				if (!blk_used[g][j]) begin
					r.status = gbba_pkg::ST_ALREADY_FREE;
				end else begin
					blk_used[g][j] = 1'b0;
					grp_count[g]--;
					used_total--;
					r.status = gbba_pkg::ST_OK;
				end
			end
		end
		r.total_used = gbba_pkg::BLK_W'(used_total);
		return r;
	endfunction

	// Walk from a random point to the next block in use; fall back to any in-range block.
	function automatic int find_used_block(int span);
		int bpg, start, k, idx;
		bpg = eff_bpg();
		start = $urandom_range(0, span - 1);
		for (k = 0; k < span; k++) begin
			idx = (start + k) % span;
			if (blk_used[idx / bpg][idx % bpg])
				return idx + 1;
		end
		return $urandom_range(1, span);
	endfunction

	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic issue(logic c, int blk);
		gbba_pkg::in_item_t it;
		while (cmd_backlog.size() >= 2) @(negedge clk);
		it.command = c;
		it.block_number = gbba_pkg::BLK_W'(blk);
		cmd_backlog.push_back(it);
		cmds_sent++;
	endtask

	task automatic random_command(int alloc_pct);
		int span, r;
		span = eff_groups() * eff_bpg();
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			issue(gbba_pkg::CMD_ALLOC, $urandom_range(0, 16383));
		end else begin
			r = $urandom_range(0, 9);
			if (r < 7)
				issue(gbba_pkg::CMD_FREE, find_used_block(span));
			else if (r < 9)
				issue(gbba_pkg::CMD_FREE, $urandom_range(1, span + 2));
			else
				issue(gbba_pkg::CMD_FREE, $urandom_range(0, 16383));
		end
	endtask

	// Wait until every command has been answered, then write both registers.
	task automatic set_config(int bpg, int grp);
		while (cmds_taken != cmds_sent || awaited_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= gbba_pkg::REG_BLOCKS_PER_GROUP;
		cfg_data <= gbba_pkg::CFG_W'(bpg);
		@(negedge clk);
		cfg_index <= gbba_pkg::REG_GROUPS_IN_USE;
		cfg_data <= gbba_pkg::CFG_W'(grp);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// command driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else if (cmd_backlog.size() > 0) begin
				in_data <= cmd_backlog.pop_front();
				in_valid <= 1'b1;
				tx_gap = next_gap(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with a long hold-off twice during the run
	always @(negedge clk) begin
		if (rx_hold == 0 && results_seen >= hold_mark) begin
			rx_hold = 400;
			hold_mark += 400;
		end
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else if (rx_gap > 0) begin
			out_stall <= 1'b1;
			rx_gap--;
		end else begin
			out_stall <= 1'b0;
			rx_gap = next_gap(rx_calm);
		end
	end

	// monitor: track registers, check results, predict accepted commands
	always @(posedge clk) begin
		gbba_pkg::out_item_t want;
		in_fire <= in_valid && !in_stall;
		if (cfg_we) begin
			if (cfg_index == gbba_pkg::REG_BLOCKS_PER_GROUP)
				bpg_shadow = cfg_data[gbba_pkg::BPG_REG_W-1:0];
			else
				grp_shadow = cfg_data[gbba_pkg::GRP_REG_W-1:0];
		end
		if (out_valid && !out_stall) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: status %0d block %0d total %0d",
						out_data.status, out_data.allocated_block, out_data.total_used);
			end else begin
				want = awaited_results.pop_front();
				if (out_data.status !== want.status
						|| out_data.allocated_block !== want.allocated_block
						|| out_data.total_used !== want.total_used) begin
					bad_results++;
					if (bad_results <= 10)
						$display({"result %0d mismatch: status %0d/%0d block %0d/%0d",
							" total %0d/%0d (got/exp)"},
							results_seen, out_data.status, want.status,
							out_data.allocated_block, want.allocated_block,
							out_data.total_used, want.total_used);
				end
			end
		end
		if (in_valid && !in_stall) begin
			awaited_results.push_back(apply_block_command(in_data));
			cmds_taken++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int p, n;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset sizes: reuse, zero, largest valid, just past the end, all ones
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_ALLOC, 16383);
		issue(gbba_pkg::CMD_FREE, 1);
		issue(gbba_pkg::CMD_FREE, 1);
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_FREE, 0);
		issue(gbba_pkg::CMD_FREE, 8192);
		issue(gbba_pkg::CMD_FREE, 8193);
		issue(gbba_pkg::CMD_FREE, 16383);
		issue(gbba_pkg::CMD_FREE, 2);
		issue(gbba_pkg::CMD_FREE, 1);

		// single block pool: grant, nothing free, out of range
		set_config(1, 1);
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_FREE, 2);
		issue(gbba_pkg::CMD_FREE, 1);
		issue(gbba_pkg::CMD_FREE, 1);

		// zero registers saturate to one
		set_config(0, 0);
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_FREE, 1);

		// oversized registers saturate to the maximum
		set_config(2047, 15);
		issue(gbba_pkg::CMD_ALLOC, 0);
		issue(gbba_pkg::CMD_FREE, 8192);
		issue(gbba_pkg::CMD_FREE, 5461);
		issue(gbba_pkg::CMD_FREE, 10922);

		for (p = 0; p < NUM_PHASES; p++) begin
			set_config(phase_bpg[p], phase_grp[p]);
			for (n = 0; n < phase_items[p]; n++)
				random_command(phase_alloc[p]);
		end

		while (cmds_taken != cmds_sent || awaited_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (bad_results == 0 && awaited_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
src/gbba_pkg.sv
src/gbba_bitmap_mem.sv
src/gbba_locate.sv
src/grouped_bitmap_block_allocator.sv
sim/tb_top.sv
